FILE: src/rtttl_note_to_tune_byte_defines.svh
// Assertion macros used by the checker file
`ifndef RTTTL_NOTE_TO_TUNE_BYTE_DEFINES_SVH
`define RTTTL_NOTE_TO_TUNE_BYTE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define RTNB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RTNB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rtnb_pkg.sv
package rtnb_pkg;

    // Token parse phase
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_LETTER = 3'd1,
        PH_SHARP  = 3'd2,
        PH_OCTAVE = 3'd3,
        PH_IGNORE = 3'd4
    } phase_t;

    // Configuration register indexes
    localparam logic REG_DEFAULT_DURATION = 1'b0;
    localparam logic REG_DEFAULT_OCTAVE   = 1'b1;

    // Characters of interest
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SHARP = 8'h23;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] PAUSE_CODE = 4'hF;

    // Parsed note of a finished token, before defaults are applied
    typedef struct packed {
        logic [3:0] pitch;
        logic       oct_seen;
        logic [1:0] oct;
        logic       dur_seen;
        logic [1:0] dur;
    } note_t;

endpackage

FILE: src/rtnb_token.sv
module rtnb_token (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic [7:0]      text_char,
    input  logic            last_char,
    output logic            note_end,
    output rtnb_pkg::note_t note
);
    import rtnb_pkg::*;

    phase_t     phase_reg, phase_next, cons_phase;
    logic [1:0] dur_reg, dur_next, cons_dur;
    logic       dur_seen_reg, dur_seen_next, cons_dur_seen;
    logic [7:0] letter_reg, letter_next, cons_letter;
    logic       sharp_reg, sharp_next, cons_sharp;
    logic [1:0] oct_reg, oct_next, cons_oct;
    logic       oct_seen_reg, oct_seen_next, cons_oct_seen;

    logic       is_comma, is_digit;
    logic [2:0] dur_dec, oct_dec;   // {seen, code}
    logic [3:0] pitch;

    assign is_comma = (text_char == CHAR_COMMA);
    assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
    assign note_end = is_comma || last_char;

    // Duration digit decode
    always_comb begin
        unique case (text_char)
            8'h34:   dur_dec = 3'b1_00;
            8'h38:   dur_dec = 3'b1_01;
            8'h31:   dur_dec = 3'b1_10;
            8'h32:   dur_dec = 3'b1_11;
            default: dur_dec = 3'b0_00;
        endcase
    end

    // Octave digit decode
    always_comb begin
        unique case (text_char)
            8'h35:   oct_dec = 3'b1_10;
            8'h36:   oct_dec = 3'b1_00;
            8'h37:   oct_dec = 3'b1_01;
            default: oct_dec = 3'b0_00;
        endcase
    end

    // Phase after this character (a comma does not advance the phase)
    always_comb begin
        cons_phase = phase_reg;
        if (!is_comma) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (text_char != CHAR_SPACE)
                        cons_phase = is_digit ? PH_LETTER : PH_SHARP;
                end
                PH_LETTER: cons_phase = PH_SHARP;
                PH_SHARP:  cons_phase = (text_char == CHAR_SHARP) ? PH_OCTAVE : PH_IGNORE;
                default:   cons_phase = PH_IGNORE;
            endcase
        end
    end

    // Held fields after this character
    always_comb begin
        cons_dur      = dur_reg;
        cons_dur_seen = dur_seen_reg;
        cons_letter   = letter_reg;
        cons_sharp    = sharp_reg;
        cons_oct      = oct_reg;
        cons_oct_seen = oct_seen_reg;
        if (!is_comma) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (text_char != CHAR_SPACE) begin
                        if (is_digit) begin
                            cons_dur_seen = dur_dec[2];
                            cons_dur      = dur_dec[1:0];
                        end else begin
                            cons_letter = text_char;
                        end
                    end
                end
                PH_LETTER: cons_letter = text_char;
                PH_SHARP: begin
                    if (text_char == CHAR_SHARP) begin
                        cons_sharp = 1'b1;
                    end else if (is_digit) begin
                        cons_oct_seen = oct_dec[2];
                        cons_oct      = oct_dec[1:0];
                    end
                end
                PH_OCTAVE: begin
                    if (is_digit) begin
                        cons_oct_seen = oct_dec[2];
                        cons_oct      = oct_dec[1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Pitch from letter and sharp
    always_comb begin
        logic [3:0] base;
        logic       may_sharp;
        base      = PAUSE_CODE;
        may_sharp = 1'b1;
        unique case (cons_letter)
            8'h63: base = 4'd0;
            8'h64: base = 4'd2;
            8'h65: begin base = 4'd4;  may_sharp = 1'b0; end
            8'h66: base = 4'd5;
            8'h67: base = 4'd7;
            8'h61: base = 4'd9;
            8'h62: begin base = 4'd11; may_sharp = 1'b0; end
            default: may_sharp = 1'b0;
        endcase
        if (cons_sharp && base != PAUSE_CODE)
            pitch = may_sharp ? base + 4'd1 : PAUSE_CODE;
        else
            pitch = base;
    end

    // Fields in struct order: pitch, oct_seen, oct, dur_seen, dur
    assign note = {pitch, cons_oct_seen, cons_oct, cons_dur_seen, cons_dur};

    // Token clears once its note goes out
    always_comb begin
        phase_next    = note_end ? PH_SKIP : cons_phase;
        dur_next      = note_end ? 2'd0 : cons_dur;
        dur_seen_next = note_end ? 1'b0 : cons_dur_seen;
        letter_next   = note_end ? 8'd0 : cons_letter;
        sharp_next    = note_end ? 1'b0 : cons_sharp;
        oct_next      = note_end ? 2'd0 : cons_oct;
        oct_seen_next = note_end ? 1'b0 : cons_oct_seen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SKIP;
            dur_reg      <= 2'd0;
            dur_seen_reg <= 1'b0;
            letter_reg   <= 8'd0;
            sharp_reg    <= 1'b0;
            oct_reg      <= 2'd0;
            oct_seen_reg <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            dur_reg      <= dur_next;
            dur_seen_reg <= dur_seen_next;
            letter_reg   <= letter_next;
            sharp_reg    <= sharp_next;
            oct_reg      <= oct_next;
            oct_seen_reg <= oct_seen_next;
        end
    end

endmodule

FILE: src/rtttl_note_to_tune_byte.sv
// Ringtone note-list parser: one ASCII character in, at most one packed note out.
//
// Input stream s_*: s_tdata carries one character, s_tlast marks the final
// character of the list. A comma or the final character closes a token and
// yields one note; every other character yields nothing.
// Output stream m_*: the note, one transfer per closed token.
// Config port: cfg_we/cfg_addr/cfg_wdata set the default duration (index 0)
// and default octave (index 1); write only while the block is idle.
//
// The note appears on m_* in the cycle after the closing character's
// transfer. Characters are taken one per cycle while s_tready is high; the
// token state update and note decode are combinational, ahead of the output register.
// Reset (synchronous, aresetn low): token state cleared, defaults zero,
// output empty. When the receiver stalls with a note held, s_tready drops
// until that note is taken; characters that produce no note still need the
// output register free only through this same s_tready.
module rtttl_note_to_tune_byte (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_char
    input  logic        s_tlast,    // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] tune_byte, [11:8] pitch_code,
                                    // [13:12] octave_code, [15:14] duration_code
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata
);
    import rtnb_pkg::*;

    logic [1:0]  def_dur_reg, def_oct_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic        s_xfer, note_end;
    note_t       note;
    logic [1:0]  oct_code, dur_code;

    // Output register takes a new note whenever empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    rtnb_token u_token (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_xfer),
        .text_char (s_tdata),
        .last_char (s_tlast),
        .note_end  (note_end),
        .note      (note)
    );

    // Defaults fill in what the token did not give
    assign oct_code     = note.oct_seen ? note.oct : def_oct_reg;
    assign dur_code     = note.dur_seen ? note.dur : def_dur_reg;
    assign m_tdata_next = {dur_code, oct_code, note.pitch, dur_code, oct_code, note.pitch};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_xfer)
            m_tvalid_next = note_end;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && note_end) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_dur_reg <= 2'd0;
            def_oct_reg <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEFAULT_DURATION: def_dur_reg <= cfg_wdata;
                REG_DEFAULT_OCTAVE:   def_oct_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/rtnb_checker.sv
`include "rtttl_note_to_tune_byte_defines.svh"

module rtnb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import rtnb_pkg::*;

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    // Packed byte agrees with the separate fields
    `RTNB_ASSERT_IMP(a_byte_fields, aclk, aresetn, m_tvalid,
        m_tdata[3:0] == m_tdata[11:8] && m_tdata[7:4] == m_tdata[15:12],
        "tune byte disagrees with its fields")

    // Pitch is a semitone or the pause code
    `RTNB_ASSERT_IMP(a_pitch_range, aclk, aresetn, m_tvalid,
        m_tdata[11:8] <= 4'd11 || m_tdata[11:8] == PAUSE_CODE,
        "pitch code out of range")

    // A closing character always yields a note next cycle
    `RTNB_ASSERT_NXT(a_close_emits, aclk, aresetn,
        s_xfer && (s_tdata == CHAR_COMMA || s_tlast), m_tvalid,
        "closed token produced no note")

    // Other characters never invent a note
    `RTNB_ASSERT_NXT(a_no_spurious, aclk, aresetn,
        s_xfer && s_tdata != CHAR_COMMA && !s_tlast && (!m_tvalid || m_tready),
        !m_tvalid, "note produced without a closing character")

    // A stalled note holds
    `RTNB_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled note changed")

endmodule

bind rtttl_note_to_tune_byte rtnb_checker u_rtnb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
